// ===== hdl/code39_bar_width_decoder_core_macros.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef CODE39_BAR_WIDTH_DECODER_CORE_MACROS_SVH
`define CODE39_BAR_WIDTH_DECODER_CORE_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define C39_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define C39_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/c39bwd_pkg.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar-width decoder package
// Transaction types, element codes, reset values and the pattern table.
// ----------------------------------------------------------------------------
`default_nettype none

package c39bwd_pkg;

  localparam int unsigned WINDOW_LEN    = 10;
  localparam int unsigned PAT_LEN       = 16;
  localparam int unsigned TABLE_ENTRIES = 57;
  localparam int unsigned TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int unsigned SYM_W         = 3;
  localparam int unsigned CHAR_W        = 7;
  localparam int unsigned DUR_W         = 16;
  localparam int unsigned CFG_W         = 16;

  localparam logic [CFG_W-1:0] THIN_LIMIT_RST = 16'd1500;
  localparam logic [CFG_W-1:0] WIDE_LIMIT_RST = 16'd5000;

  // Register indexes
  localparam logic CFG_THIN_LIMIT = 1'b0;
  localparam logic CFG_WIDE_LIMIT = 1'b1;

  // Element codes
  localparam logic [SYM_W-1:0] SYM_THIN_ONE  = 3'd0;
  localparam logic [SYM_W-1:0] SYM_WIDE_ONE  = 3'd1;
  localparam logic [SYM_W-1:0] SYM_THIN_ZERO = 3'd2;
  localparam logic [SYM_W-1:0] SYM_WIDE_ZERO = 3'd3;
  localparam logic [SYM_W-1:0] SYM_UNKNOWN   = 3'd4;
  localparam logic [SYM_W-1:0] SYM_EMPTY     = 3'd5;

  // Edge history codes
  localparam logic [1:0] PREV_NONE = 2'd0;
  localparam logic [1:0] PREV_RISE = 2'd1;
  localparam logic [1:0] PREV_FALL = 2'd2;

  typedef struct packed {
    logic             kind;
    logic [DUR_W-1:0] duration_ms;
  } in_data_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol;
    logic              matched;
    logic [CHAR_W-1:0] character;
  } out_data_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic [PAT_LEN-1:0] pat;
  } pat_entry_t;

  function automatic pat_entry_t pat_table(input logic [TBL_IDX_W-1:0] idx);
    pat_entry_t e;
    case (idx)
      6'd0:  e = '{7'h2A, 16'b1000101110111010};
      6'd1:  e = '{7'h2A, 16'b1011101110100010};
      6'd2:  e = '{7'h41, 16'b1110101000101110};
      6'd3:  e = '{7'h41, 16'b1110100010101110};
      6'd4:  e = '{7'h42, 16'b1011101000101110};
      6'd5:  e = '{7'h42, 16'b1110100010111010};
      6'd6:  e = '{7'h43, 16'b1110111010001010};
      6'd7:  e = '{7'h43, 16'b1010001011101110};
      6'd8:  e = '{7'h44, 16'b1010111000101110};
      6'd9:  e = '{7'h44, 16'b1110100011101010};
      6'd10: e = '{7'h45, 16'b1110101110001010};
      6'd11: e = '{7'h45, 16'b1010001110101110};
      6'd12: e = '{7'h46, 16'b1011101110001010};
      6'd13: e = '{7'h46, 16'b1010001110111010};
      6'd14: e = '{7'h47, 16'b1010100011101110};
      6'd15: e = '{7'h47, 16'b1110111000101010};
      6'd16: e = '{7'h48, 16'b1110101000111010};
      6'd17: e = '{7'h48, 16'b1011100010101110};
      6'd18: e = '{7'h49, 16'b1011101000111010};
      6'd19: e = '{7'h49, 16'b1011100010111010};
      6'd20: e = '{7'h4A, 16'b1010111000111010};
      6'd21: e = '{7'h4A, 16'b1011100011101010};
      6'd22: e = '{7'h4B, 16'b1110101010001110};
      6'd23: e = '{7'h4B, 16'b1110001010101110};
      6'd24: e = '{7'h4C, 16'b1011101010001110};
      6'd25: e = '{7'h4C, 16'b1110001010111010};
      6'd26: e = '{7'h4D, 16'b1110111010100010};
      6'd27: e = '{7'h4D, 16'b1000101011101110};
      6'd28: e = '{7'h4E, 16'b1010111010001110};
      6'd29: e = '{7'h4E, 16'b1110001011101010};
      6'd30: e = '{7'h4F, 16'b1110101110100010};
      6'd31: e = '{7'h4F, 16'b1000101110101110};
      6'd32: e = '{7'h50, 16'b1011101110100010};
      6'd33: e = '{7'h50, 16'b1000101110111010};
      6'd34: e = '{7'h51, 16'b1010101110001110};
      6'd35: e = '{7'h51, 16'b1110001110101010};
      6'd36: e = '{7'h52, 16'b1110101011100010};
      6'd37: e = '{7'h52, 16'b1000111010101110};
      6'd38: e = '{7'h53, 16'b1011101011100010};
      6'd39: e = '{7'h53, 16'b1000111010111010};
      6'd40: e = '{7'h54, 16'b1010111011100010};
      6'd41: e = '{7'h54, 16'b1000111011101010};
      6'd42: e = '{7'h55, 16'b1110001010101110};
      6'd43: e = '{7'h55, 16'b1110101010001110};
      6'd44: e = '{7'h56, 16'b1000111010101110};
      6'd45: e = '{7'h56, 16'b1110101011100010};
      6'd46: e = '{7'h57, 16'b1110001110101010};
      6'd47: e = '{7'h57, 16'b1010101110001110};
      6'd48: e = '{7'h58, 16'b1000101110101110};
      6'd49: e = '{7'h58, 16'b1110101110100010};
      6'd50: e = '{7'h59, 16'b1110001011101010};
      6'd51: e = '{7'h59, 16'b1010111010001110};
      6'd52: e = '{7'h5A, 16'b1000111011101010};
      6'd53: e = '{7'h5A, 16'b1010111011100010};
      6'd54: e = '{7'h2D, 16'b1000101011101110};
      6'd55: e = '{7'h2E, 16'b1110001010111010};
      6'd56: e = '{7'h20, 16'b1000111010111010};
      default: e = '{7'h00, 16'b0000000000000000};
    endcase
    return e;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/code39_bar_width_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Code 39 bar-width decoder core
// Classes durations as thin, wide or unknown elements, keeps a sliding window
// of elements and looks the window up in the Code 39 pattern table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) takes one edge
//   transaction: edge kind and the duration of the bar that just ended.
//   Output channel (out_valid_o / out_stall_i / out_data_o) returns at most
//   one transaction per input: element symbol, match flag and character.
//   A repeated edge, or a fall with an empty element count, is accepted
//   and returns nothing.
//   Otherwise the sequencer walks the 10-element window one element per
//   cycle, checks the string length and unknown elements, then, if both
//   pass, compares one pattern table entry per cycle (up to 57 entries,
//   stopping at the first match), and loads the output register once it
//   is free. There is a single table comparator.
//   in_stall_o is high while a transaction is in work.
//   If the receiver stalls, the result waits in the output register and
//   the next transaction may run; its result waits until the register frees.
//   Reset clears the window to empty, the count to zero, the edge history
//   to none and the limits to 1500 and 5000. Write cfg_* only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

`include "code39_bar_width_decoder_core_macros.svh"

module code39_bar_width_decoder_core #(
  parameter int unsigned WindowLen = c39bwd_pkg::WINDOW_LEN
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic                         cfg_index_i,
  input  wire logic [c39bwd_pkg::CFG_W-1:0] cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire c39bwd_pkg::in_data_t         in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output c39bwd_pkg::out_data_t             out_data_o
);

  localparam int unsigned IdxW   = $clog2(WindowLen);
  localparam int unsigned CntW   = $clog2(WindowLen + 1);
  localparam int unsigned LenW   = $clog2(3 * WindowLen + 1);
  localparam int unsigned PatLen = c39bwd_pkg::PAT_LEN;
  localparam int unsigned SymW   = c39bwd_pkg::SYM_W;
  localparam int unsigned CharW  = c39bwd_pkg::CHAR_W;
  localparam int unsigned TblW   = c39bwd_pkg::TBL_IDX_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_CHECK,
    ST_SEARCH,
    ST_FINISH
  } state_e;

  state_e                          state_q, state_d;
  logic [c39bwd_pkg::CFG_W-1:0]    thin_q, thin_d;
  logic [c39bwd_pkg::CFG_W-1:0]    wide_q, wide_d;
  logic [SymW-1:0]                 win_q [WindowLen];
  logic [SymW-1:0]                 win_d [WindowLen];
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic [1:0]                      prev_q, prev_d;
  logic [SymW-1:0]                 sym_q, sym_d;
  logic [IdxW-1:0]                 idx_q, idx_d;
  logic [PatLen-1:0]               text_q, text_d;
  logic [LenW-1:0]                 len_q, len_d;
  logic                            unk_q, unk_d;
  logic [TblW-1:0]                 tidx_q, tidx_d;
  logic [CharW-1:0]                ch_q, ch_d;
  logic                            out_valid_q, out_valid_d;
  c39bwd_pkg::out_data_t           out_data_q, out_data_d;

  logic                            in_fire;
  logic [1:0]                      edge_in;
  logic [SymW-1:0]                 cls;
  logic [SymW-1:0]                 elem;
  c39bwd_pkg::pat_entry_t          ent;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign edge_in = in_data_i.kind ? c39bwd_pkg::PREV_FALL : c39bwd_pkg::PREV_RISE;
  assign elem    = win_q[idx_q];
  assign ent     = c39bwd_pkg::pat_table(tidx_q);

  always_comb begin
    if ((in_data_i.duration_ms > thin_q) && (in_data_i.duration_ms < wide_q)) begin
      cls = in_data_i.kind ? c39bwd_pkg::SYM_WIDE_ONE : c39bwd_pkg::SYM_WIDE_ZERO;
    end else if (in_data_i.duration_ms < thin_q) begin
      cls = in_data_i.kind ? c39bwd_pkg::SYM_THIN_ONE : c39bwd_pkg::SYM_THIN_ZERO;
    end else begin
      cls = c39bwd_pkg::SYM_UNKNOWN;
    end
  end

  always_comb begin
    state_d     = state_q;
    thin_d      = thin_q;
    wide_d      = wide_q;
    win_d       = win_q;
    cnt_d       = cnt_q;
    prev_d      = prev_q;
    sym_d       = sym_q;
    idx_d       = idx_q;
    text_d      = text_q;
    len_d       = len_q;
    unk_d       = unk_q;
    tidx_d      = tidx_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        c39bwd_pkg::CFG_THIN_LIMIT: thin_d = cfg_data_i;
        c39bwd_pkg::CFG_WIDE_LIMIT: wide_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (edge_in != prev_q)) begin
          prev_d = edge_in;
          if (!(in_data_i.kind && (cnt_q == '0)) &&
              !(!in_data_i.kind && (cnt_q >= CntW'(WindowLen)))) begin
            sym_d = cls;
            for (int i = 0; i < WindowLen - 1; i++) begin
              win_d[i] = win_q[i+1];
            end
            win_d[WindowLen-1] = cls;
            cnt_d   = cnt_q + CntW'(1);
            idx_d   = '0;
            text_d  = '0;
            len_d   = '0;
            unk_d   = 1'b0;
            state_d = ST_BUILD;
          end
        end
      end
      ST_BUILD: begin
        case (elem)
          c39bwd_pkg::SYM_THIN_ONE: begin
            text_d = {text_q[PatLen-2:0], 1'b1};
            len_d  = len_q + LenW'(1);
          end
          c39bwd_pkg::SYM_WIDE_ONE: begin
            text_d = {text_q[PatLen-4:0], 3'b111};
            len_d  = len_q + LenW'(3);
          end
          c39bwd_pkg::SYM_THIN_ZERO: begin
            text_d = {text_q[PatLen-2:0], 1'b0};
            len_d  = len_q + LenW'(1);
          end
          c39bwd_pkg::SYM_WIDE_ZERO: begin
            text_d = {text_q[PatLen-4:0], 3'b000};
            len_d  = len_q + LenW'(3);
          end
          c39bwd_pkg::SYM_UNKNOWN: begin
            text_d = {text_q[PatLen-2:0], 1'b0};
            len_d  = len_q + LenW'(1);
            unk_d  = 1'b1;
          end
          default: ;
        endcase
        if (idx_q == IdxW'(WindowLen - 1)) begin
          state_d = ST_CHECK;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_CHECK: begin
        tidx_d = '0;
        ch_d   = '0;
        if ((len_q == LenW'(PatLen)) && !unk_q) begin
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_FINISH;
        end
      end
      ST_SEARCH: begin
        if (ent.pat == text_q) begin
          ch_d    = ent.ch;
          state_d = ST_FINISH;
        end else if (tidx_q == TblW'(c39bwd_pkg::TABLE_ENTRIES - 1)) begin
          state_d = ST_FINISH;
        end else begin
          tidx_d = tidx_q + TblW'(1);
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_data_d.symbol    = sym_q;
          out_data_d.matched   = (ch_q != '0);
          out_data_d.character = ch_q;
          if ((ch_q != '0) || (cnt_q >= CntW'(WindowLen))) begin
            cnt_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      thin_q      <= c39bwd_pkg::THIN_LIMIT_RST;
      wide_q      <= c39bwd_pkg::WIDE_LIMIT_RST;
      for (int i = 0; i < WindowLen; i++) begin
        win_q[i] <= c39bwd_pkg::SYM_EMPTY;
      end
      cnt_q       <= '0;
      prev_q      <= c39bwd_pkg::PREV_NONE;
      idx_q       <= '0;
      len_q       <= '0;
      unk_q       <= 1'b0;
      tidx_q      <= '0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      thin_q      <= thin_d;
      wide_q      <= wide_d;
      win_q       <= win_d;
      cnt_q       <= cnt_d;
      prev_q      <= prev_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      unk_q       <= unk_d;
      tidx_q      <= tidx_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    text_q     <= text_d;
    out_data_q <= out_data_d;
  end

  `C39_ASSERT_IMPL(a_match_has_char, clk_i, rst_ni, out_valid_q && out_data_q.matched, out_data_q.character != '0, "matched result without character")
  `C39_ASSERT_IMPL(a_search_len_ok, clk_i, rst_ni, state_q == ST_SEARCH, (len_q == LenW'(PatLen)) && !unk_q, "table search on a string that cannot match")
  `C39_ASSERT_IMPL(a_idle_count_range, clk_i, rst_ni, state_q == ST_IDLE, cnt_q < CntW'(WindowLen), "element count out of range while idle")
  `C39_ASSERT_NEXT(a_finish_loads, clk_i, rst_ni, (state_q == ST_FINISH) && (!out_valid_q || !out_stall_i), out_valid_q && (state_q == ST_IDLE), "result not loaded at finish")

endmodule

`default_nettype wire
